// File: hw/rtl/chacha_pkg.sv
// Shared types, constants and round functions for the ChaCha20 stream cipher.
package chacha_pkg;

  // Block constants ("expand 32-byte k")
  localparam logic [31:0] Sigma0 = 32'h6170_7865;
  localparam logic [31:0] Sigma1 = 32'h3320_646e;
  localparam logic [31:0] Sigma2 = 32'h7962_2d32;
  localparam logic [31:0] Sigma3 = 32'h6b20_6574;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned PosW     = 6;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_A      = 3'd0,
    CFG_KEY_B      = 3'd1,
    CFG_KEY_C      = 3'd2,
    CFG_KEY_D      = 3'd3,
    CFG_NONCE_LOW  = 3'd4,
    CFG_NONCE_HIGH = 3'd5,
    CFG_START_CTR  = 3'd6
  } cfg_idx_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FEED  = 4'b0100,
    ST_EMIT  = 4'b1000
  } chacha_state_e;

  typedef logic [15:0][31:0] words_t;

  typedef struct packed {
    logic [63:0] key_word_a;
    logic [63:0] key_word_b;
    logic [63:0] key_word_c;
    logic [63:0] key_word_d;
    logic [63:0] nonce_low;
    logic [31:0] nonce_high;
    logic [31:0] start_counter;
  } cfg_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       first_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_out;
  } out_req_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic start_block;
    logic round;
    logic diag;
    logic feed;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_block;
  } sts_t;

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // One quarter round on (a, b, c, d); result packed as [3]=d .. [0]=a
  function automatic logic [3:0][31:0] quarter(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] c, logic [31:0] d);
    logic [31:0] ta, tb, tc, td;
    logic [3:0][31:0] r;
    ta = a + b;   td = rotl(d ^ ta, 16);
    tc = c + td;  tb = rotl(b ^ tc, 12);
    ta = ta + tb; td = rotl(td ^ ta, 8);
    tc = tc + td; tb = rotl(tb ^ tc, 7);
    r = {td, tc, tb, ta};
    return r;
  endfunction

  // Four independent quarter rounds: columns, or diagonals when diag is set
  function automatic words_t half_round(words_t w, logic diag);
    words_t r;
    logic [3:0] ia, ib, ic, id;
    logic [3:0][31:0] q;
    r = w;
    for (int j = 0; j < 4; j++) begin
      ia = 4'(j);
      ib = diag ? 4'(4 + ((j + 1) & 3)) : 4'(4 + j);
      ic = diag ? 4'(8 + ((j + 2) & 3)) : 4'(8 + j);
      id = diag ? 4'(12 + ((j + 3) & 3)) : 4'(12 + j);
      q = quarter(w[ia], w[ib], w[ic], w[id]);
      r[ia] = q[0];
      r[ib] = q[1];
      r[ic] = q[2];
      r[id] = q[3];
    end
    return r;
  endfunction

  // Initial block state from the registers and a block counter
  function automatic words_t init_state(cfg_t cfg, logic [31:0] ctr);
    words_t s;
    s[0]  = Sigma0;
    s[1]  = Sigma1;
    s[2]  = Sigma2;
    s[3]  = Sigma3;
    s[4]  = cfg.key_word_a[31:0];
    s[5]  = cfg.key_word_a[63:32];
    s[6]  = cfg.key_word_b[31:0];
    s[7]  = cfg.key_word_b[63:32];
    s[8]  = cfg.key_word_c[31:0];
    s[9]  = cfg.key_word_c[63:32];
    s[10] = cfg.key_word_d[31:0];
    s[11] = cfg.key_word_d[63:32];
    s[12] = ctr;
    s[13] = cfg.nonce_low[31:0];
    s[14] = cfg.nonce_low[63:32];
    s[15] = cfg.nonce_high;
    return s;
  endfunction

endpackage

// File: hw/rtl/chacha20_stream_cipher_top.sv
// Top level: configuration registers, controller and datapath of the ChaCha20 stream cipher.
//
// ChaCha20 (RFC 8439) byte stream cipher. Each request carries one byte, which is
// XORed with the next keystream byte; encryption and decryption are the same. Key,
// nonce and start block counter are to be written through the configuration port
// only while the block is idle; the block itself does not enforce this. first_byte
// reloads the start counter and restarts the block position. A byte inside a block
// goes from acceptance through the emit state into the result register. The first
// byte of each 64-byte block also generates that block: one column or diagonal round
// per cycle in a shared round unit for DOUBLE_ROUNDS double rounds, then one
// feed-forward step, before the emit state. One request is in flight at a time; the
// result register lets the next request enter while a result waits to be taken.
module chacha20_stream_cipher_top #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [chacha_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [chacha_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  chacha_pkg::in_req_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output chacha_pkg::out_req_t                out_data_o
);

  chacha_pkg::cfg_t cfg_q;
  chacha_pkg::cmd_t cmd;
  chacha_pkg::sts_t sts;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        chacha_pkg::CFG_KEY_A:      cfg_q.key_word_a    <= cfg_data_i;
        chacha_pkg::CFG_KEY_B:      cfg_q.key_word_b    <= cfg_data_i;
        chacha_pkg::CFG_KEY_C:      cfg_q.key_word_c    <= cfg_data_i;
        chacha_pkg::CFG_KEY_D:      cfg_q.key_word_d    <= cfg_data_i;
        chacha_pkg::CFG_NONCE_LOW:  cfg_q.nonce_low     <= cfg_data_i;
        chacha_pkg::CFG_NONCE_HIGH: cfg_q.nonce_high    <= cfg_data_i[31:0];
        chacha_pkg::CFG_START_CTR:  cfg_q.start_counter <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  chacha_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chacha_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

// File: hw/rtl/chacha_ctrl.sv
// Controller state machine: sequences request intake, rounds, feed-forward and result.
module chacha_ctrl #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  chacha_pkg::sts_t    sts_i,
  output chacha_pkg::cmd_t    cmd_o
);

  localparam int unsigned NumRounds = 2 * DOUBLE_ROUNDS;
  localparam int unsigned RndW      = $clog2(NumRounds);

  chacha_pkg::chacha_state_e state_q, state_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;
  logic            last_rnd;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign last_rnd   = (rnd_q == RndW'(NumRounds - 1));
  assign in_ready_o  = (state_q == chacha_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    cmd_o   = '0;
    case (state_q)
      chacha_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.need_block) begin
            cmd_o.start_block = 1'b1;
            rnd_d   = '0;
            state_d = chacha_pkg::ST_ROUND;
          end else begin
            state_d = chacha_pkg::ST_EMIT;
          end
        end
      end
      chacha_pkg::ST_ROUND: begin
        cmd_o.round = 1'b1;
        cmd_o.diag  = rnd_q[0];
        rnd_d       = rnd_q + 1'b1;
        if (last_rnd) begin
          state_d = chacha_pkg::ST_FEED;
        end
      end
      chacha_pkg::ST_FEED: begin
        cmd_o.feed = 1'b1;
        state_d    = chacha_pkg::ST_EMIT;
      end
      chacha_pkg::ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = chacha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = chacha_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold result valid until the request is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chacha_pkg::ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_block_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_block |=> (state_q == chacha_pkg::ST_ROUND) && (rnd_q == '0))
    else $error("block start did not enter round sequence");

  a_rounds_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chacha_pkg::ST_ROUND) && last_rnd |=> (state_q == chacha_pkg::ST_FEED))
    else $error("round sequence did not end in feed-forward");

  a_feed_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.feed |=> (state_q == chacha_pkg::ST_EMIT))
    else $error("feed-forward not followed by result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");
`endif

endmodule

// File: hw/rtl/chacha_dp.sv
// Datapath: block state, round unit, keystream words, position, counter and result.
module chacha_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  chacha_pkg::cfg_t     cfg_i,
  input  chacha_pkg::in_req_t  in_data_i,
  input  chacha_pkg::cmd_t     cmd_i,
  output chacha_pkg::sts_t     sts_o,
  output chacha_pkg::out_req_t out_data_o
);

  chacha_pkg::words_t work_q;
  chacha_pkg::words_t ks_q;
  chacha_pkg::words_t init_ff;
  logic [31:0] ctr_q, ctr_eff, ctr_init_q;
  logic [chacha_pkg::PosW-1:0] pos_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;
  chacha_pkg::out_req_t out_q;

  // Block needed at message start or block boundary
  assign sts_o.need_block = in_data_i.first_byte || (pos_q == '0);
  assign ctr_eff = in_data_i.first_byte ? cfg_i.start_counter : ctr_q;

  // Feed-forward source uses the counter saved for this block
  assign init_ff = chacha_pkg::init_state(cfg_i, ctr_init_q);

  // Select the keystream byte at the current position
  assign ks_word = ks_q[pos_q[5:2]];
  assign ks_byte = 8'(ks_word >> {pos_q[1:0], 3'b000});

  assign out_data_o = out_q;

  // Control state: block counter and byte position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
      pos_q <= '0;
    end else begin
      if (cmd_i.accept && in_data_i.first_byte) begin
        pos_q <= '0;
      end else if (cmd_i.emit) begin
        pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.start_block) begin
        ctr_q <= ctr_eff + 32'd1;
      end
    end
  end

  // Payload: request capture, working state, keystream words, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_data_i.plain_byte;
      last_q <= in_data_i.last_byte;
    end
    if (cmd_i.start_block) begin
      work_q     <= chacha_pkg::init_state(cfg_i, ctr_eff);
      ctr_init_q <= ctr_eff;
    end else if (cmd_i.round) begin
      work_q <= chacha_pkg::half_round(work_q, cmd_i.diag);
    end
    if (cmd_i.feed) begin
      for (int i = 0; i < 16; i++) begin
        ks_q[i] <= work_q[i] + init_ff[i];
      end
    end
    if (cmd_i.emit) begin
      out_q.cipher_byte <= byte_q ^ ks_byte;
      out_q.last_out    <= last_q;
    end
  end

endmodule
